FILE: design/bpmc_pkg.sv
// Shared types, constants and the base64 decoder of the pattern match counter.
`default_nettype none
package bpmc_pkg;

  localparam int CHAR_BITS  = 8;
  localparam int PIX_PER_CH = 6;
  localparam int COUNT_W    = 21;
  localparam int OUT_BYTES_W = 24;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes of the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_SIZE = 2'd2;

  // op codes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_IMAGE   = 1'b1;

  // decoded request passed from front to back
  typedef struct packed {
    logic                  op;
    logic [PIX_PER_CH-1:0] pix;
  } item_t;

  function automatic logic [PIX_PER_CH-1:0] decode64(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] v;
    v = '0;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == 8'h2B) v = 8'd62;
    else if (c == 8'h2F) v = 8'd63;
    return v[PIX_PER_CH-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/bpmc_front.sv
// Front end: accepts characters, decodes base64 and queues requests.
`default_nettype none
module bpmc_front import bpmc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [CHAR_BITS-1:0] in_char,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output item_t                     out_item
);

  localparam int DEPTH = 4;

  item_t      q [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt != 3'(DEPTH));
  assign out_valid = (cnt != 3'd0);
  assign out_item  = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: in_op, pix: decode64(in_char)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/bpmc_back.sv
// Back end: pattern store, line memory, sliding window, compare and count.
`default_nettype none
module bpmc_back import bpmc_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_PATTERN = 16,
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int RW = $clog2(MAX_HEIGHT + 1),
  parameter int PW = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [WW-1:0]      img_w,
  input  wire logic [RW-1:0]      img_h,
  input  wire logic [PW-1:0]      pat_p,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire item_t              in_item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [COUNT_W-1:0]      res_count
);

  localparam int MP  = MAX_PATTERN;
  localparam int IW  = (MP > 1) ? $clog2(MP) : 1;
  localparam int HW  = (MP > 1) ? MP - 1 : 1;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + PIX_PER_CH + 1);
  localparam int PCW = $clog2(MP + PIX_PER_CH + 1);
  localparam int XW  = CW + RW + PW;

  typedef logic [MP-1:0] mrow_t;
  typedef mrow_t [MP-1:0] mat_t;

  // row flip within size pp: r[i] = m[pp-1-i]
  function automatic mat_t flipr(input mat_t m, input logic [PW-1:0] pp);
    mat_t          r;
    logic [PW-1:0] ix;
    r = '0;
    for (int i = 0; i < MP; i++) begin
      ix   = pp - PW'(1) - PW'(i);
      r[i] = m[ix[IW-1:0]];
    end
    return r;
  endfunction

  // column flip within size pp: r[i][j] = m[i][pp-1-j]
  function automatic mat_t flipc(input mat_t m, input logic [PW-1:0] pp);
    mat_t          r;
    logic [PW-1:0] ix;
    r = '0;
    for (int j = 0; j < MP; j++) begin
      ix = pp - PW'(1) - PW'(j);
      for (int i = 0; i < MP; i++) r[i][j] = m[i][ix[IW-1:0]];
    end
    return r;
  endfunction

  function automatic mat_t transp(input mat_t m);
    mat_t r;
    for (int i = 0; i < MP; i++)
      for (int j = 0; j < MP; j++) r[i][j] = m[j][i];
    return r;
  endfunction

  // pattern store and load position
  mat_t            pat;
  logic [PW-1:0]   pat_row;
  logic [PCW-1:0]  pat_col;
  mat_t            orient [8];
  mat_t            orient_next [8];
  mrow_t           msk;

  // issue control
  logic [2:0]      k;
  logic [CW-1:0]   column_position;
  logic [RW-1:0]   row_position;
  logic            emit_pend;
  logic            pop_pat;
  logic            issue;
  logic            pop_img;
  logic [CW-1:0]   iss_col;
  logic            iss_wr;
  logic            iss_chk;
  logic            iss_last;
  logic            last_ch;
  logic [CW-1:0]   col_sum;

  // pipeline
  logic            s1_act, s1_wr, s1_chk, s1_last, s1_pix;
  logic [CW-1:0]   s1_col;
  logic [HW-1:0]   line_mem [MAX_WIDTH];
  logic [HW-1:0]   rd_data;
  logic            byp;
  logic [HW-1:0]   byp_data;
  logic [HW-1:0]   hist;
  logic [HW:0]     newcol;
  mrow_t           win [MP];
  logic            s2_act, s2_chk, s2_last;
  logic            s3_act, s3_match, s3_last;
  logic            any_match;
  logic [COUNT_W-1:0] match_total;
  logic [COUNT_W-1:0] tot_sum;

  // ---------------- orientations ----------------
  always_comb begin
    mat_t tp;
    tp = transp(pat);
    orient_next[0] = pat;
    orient_next[1] = flipc(tp, pat_p);
    orient_next[2] = flipr(flipc(pat, pat_p), pat_p);
    orient_next[3] = flipr(tp, pat_p);
    orient_next[4] = flipc(pat, pat_p);
    orient_next[5] = tp;
    orient_next[6] = flipr(pat, pat_p);
    orient_next[7] = flipr(flipc(tp, pat_p), pat_p);
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 8; t++) orient[t] <= orient_next[t];
    for (int i = 0; i < MP; i++) msk[i] <= (PW'(i) < pat_p);
  end

  // ---------------- issue ----------------
  // only the last character of an image waits for a held result
  assign pop_pat = in_valid && (in_item.op == OP_PATTERN) && (k == 3'd0)
                   && !s1_act && !s2_act;
  assign issue   = in_valid && (in_item.op == OP_IMAGE)
                   && ((k != 3'd0) || (!emit_pend && !(res_valid && last_ch)));
  assign pop_img = issue && (k == 3'(PIX_PER_CH - 1));
  assign in_ready = pop_pat || pop_img;

  assign iss_col = column_position + CW'(k);
  assign iss_wr  = XW'(iss_col) < XW'(img_w);
  assign iss_chk = iss_wr && (XW'(row_position) + XW'(1) >= XW'(pat_p))
                   && (XW'(iss_col) + XW'(1) >= XW'(pat_p));
  assign col_sum = column_position + CW'(PIX_PER_CH);
  assign last_ch = (XW'(col_sum) >= XW'(img_w))
                   && (XW'(row_position) + XW'(1) >= XW'(img_h));
  assign iss_last = pop_img && last_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      k               <= '0;
      column_position <= '0;
      row_position    <= '0;
      emit_pend       <= 1'b0;
      pat_row         <= '0;
      pat_col         <= '0;
    end else begin
      if (issue) k <= pop_img ? 3'd0 : k + 3'd1;
      if (pop_img) begin
        if (XW'(col_sum) >= XW'(img_w)) begin
          column_position <= '0;
          row_position    <= iss_last ? '0 : row_position + RW'(1);
        end else begin
          column_position <= col_sum;
        end
      end
      if (iss_last) emit_pend <= 1'b1;
      else if (s3_act && s3_last) emit_pend <= 1'b0;
      if (pop_pat) begin
        logic [PW-1:0]  prow;
        logic [PCW-1:0] pcol;
        prow = (pat_row >= pat_p) ? '0 : pat_row;
        pcol = (pat_row >= pat_p) ? '0 : pat_col;
        if (XW'(pcol) + XW'(PIX_PER_CH) >= XW'(pat_p)) begin
          pat_col <= '0;
          pat_row <= (prow + PW'(1) >= pat_p) ? '0 : prow + PW'(1);
        end else begin
          pat_col <= pcol + PCW'(PIX_PER_CH);
          pat_row <= prow;
        end
      end
    end
  end

  // pattern pixel writes, MSB first
  always_ff @(posedge clk) begin
    if (pop_pat) begin
      logic [PW-1:0]  prow;
      logic [PCW-1:0] pcol;
      logic [PCW-1:0] c;
      prow = (pat_row >= pat_p) ? '0 : pat_row;
      pcol = (pat_row >= pat_p) ? '0 : pat_col;
      for (int b = 0; b < PIX_PER_CH; b++) begin
        c = pcol + PCW'(b);
        if (XW'(c) < XW'(pat_p))
          pat[prow[IW-1:0]][c[IW-1:0]] <= in_item.pix[PIX_PER_CH-1-b];
      end
    end
  end

  // ---------------- stage 1: line memory ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_act <= 1'b0;
    end else begin
      s1_act <= issue;
    end
    s1_wr    <= issue && iss_wr;
    s1_chk   <= issue && iss_chk;
    s1_last  <= iss_last;
    s1_col   <= iss_col;
    s1_pix   <= in_item.pix[3'(PIX_PER_CH - 1) - k];
    byp      <= s1_wr && (s1_col[AW-1:0] == iss_col[AW-1:0]);
    byp_data <= newcol[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (s1_wr) line_mem[s1_col[AW-1:0]] <= newcol[HW-1:0];
    rd_data <= line_mem[iss_col[AW-1:0]];
  end

  // bit 0 is the newest row; bit i is i rows up
  assign hist   = byp ? byp_data : rd_data;
  assign newcol = {hist, s1_pix};

  // ---------------- stage 2: window ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_act <= 1'b0;
      for (int i = 0; i < MP; i++) win[i] <= '0;
    end else begin
      s2_act <= s1_act;
      if (s1_wr) begin
        win[0] <= newcol[MP-1:0];
        for (int i = 1; i < MP; i++) win[i] <= win[i-1];
      end
    end
    s2_chk  <= s1_chk;
    s2_last <= s1_last;
  end

  // window seen from the bottom-right corner against the eight orientations;
  // the orientation set is closed under half turn, so anchoring is free
  always_comb begin
    logic ok;
    any_match = 1'b0;
    for (int t = 0; t < 8; t++) begin
      ok = 1'b1;
      for (int a = 0; a < MP; a++)
        for (int b = 0; b < MP; b++)
          if (msk[a] && msk[b] && (win[b][a] != orient[t][a][b])) ok = 1'b0;
      if (ok) any_match = 1'b1;
    end
  end

  // ---------------- stage 3: count ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_act <= 1'b0;
    end else begin
      s3_act <= s2_act;
    end
    s3_match <= s2_chk && any_match;
    s3_last  <= s2_last;
  end

  assign tot_sum = (s3_match && match_total != COUNT_MAX) ? match_total + COUNT_W'(1)
                                                         : match_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (s3_act) begin
        if (s3_last) begin
          match_total <= '0;
          res_valid   <= 1'b1;
        end else begin
          match_total <= tot_sum;
        end
      end
    end
    if (s3_act && s3_last) res_count <= tot_sum;
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !(emit_pend && res_valid)) else $error("pending emit while result held");
  a_pat_quiet: assert property (@(posedge clk) disable iff (rst)
    pop_pat |-> !s1_act && !s2_act) else $error("pattern write during compare");
  a_mid_item: assert property (@(posedge clk) disable iff (rst)
    (k != 3'd0) |-> in_valid && (in_item.op == OP_IMAGE))
    else $error("image request left mid-character");
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    iss_last |=> s1_act && s1_last) else $error("end of image lost");

endmodule
`default_nettype wire

FILE: design/binary_pattern_match_counter_core.sv
// Top level of the binary pattern match counter: config registers and the two halves.
`default_nettype none
// Counts window positions of a binary image that equal a square pattern in any of its
// eight orientations. Each request is one base64 character (tdata) carrying six pixels,
// MSB first; tuser is 0 for pattern rows, 1 for image rows. Load the pattern rows first,
// then stream the image row by row; one result (match count, 21 bits, saturating) leaves
// after the last character of the last row. An image character is fed into the back end
// one pixel per cycle through the line memory, window and comparator, so the next
// character is taken only once all pixels of the current one are issued; a pattern character is taken
// once no image pixel is in the compare pipeline. After each image the next image
// character waits for the count to drain. The count register holds one result, so the
// next image streams on while it waits; only that image's last character waits until
// the previous result is taken.
// A four-deep request queue between decoder and back end lets either side stall.
// Configuration must be written only while the block is idle; the block does not enforce it.
module binary_pattern_match_counter_core import bpmc_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [CHAR_BITS-1:0]   s_axis_tdata,   // [7:0] char_code
  input  wire logic                   s_axis_tuser,   // [0] op
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_BYTES_W-1:0]      m_axis_tdata,   // [20:0] match_count, rest zero
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_PATTERN + 1);

  logic [WW-1:0] img_w;
  logic [RW-1:0] img_h;
  logic [PW-1:0] pat_p;
  logic [4:0]    p_raw;
  item_t         q_item;
  logic          q_valid;
  logic          q_ready;
  logic [COUNT_W-1:0] count;

  assign p_raw = cfg_data[4:0];

  // registers, clamped into range on write (pattern size taken from cfg_data[4:0])
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
      img_h <= RW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
      pat_p <= PW'(MAX_PATTERN < 16 ? MAX_PATTERN : 16);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data == '0) img_w <= WW'(1);
          else if (32'(cfg_data) > MAX_WIDTH) img_w <= WW'(MAX_WIDTH);
          else img_w <= WW'(cfg_data);
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) img_h <= RW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) img_h <= RW'(MAX_HEIGHT);
          else img_h <= RW'(cfg_data);
        end
        CFG_PATTERN_SIZE: begin
          if (p_raw == '0) pat_p <= PW'(1);
          else if (32'(p_raw) > MAX_PATTERN) pat_p <= PW'(MAX_PATTERN);
          else pat_p <= PW'(p_raw);
        end
        default: begin
        end
      endcase
    end
  end

  bpmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_char   (s_axis_tdata),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  bpmc_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .img_w     (img_w),
    .img_h     (img_h),
    .pat_p     (pat_p),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_count (count)
  );

  assign m_axis_tdata = {{(OUT_BYTES_W - COUNT_W){1'b0}}, count};

endmodule
`default_nettype wire
